// ----- rtl/predicate_filter_bitmap_defines.svh -----
// ----------------------------------------------------------------------------
// predicate_filter_bitmap_defines.svh
// Assertion macros shared by the predicate filter RTL.
// ----------------------------------------------------------------------------
`ifndef PREDICATE_FILTER_BITMAP_DEFINES_SVH
`define PREDICATE_FILTER_BITMAP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("predicate filter check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("predicate filter check failed");

`endif

// ----- rtl/pfb_pkg.sv -----
// ----------------------------------------------------------------------------
// pfb_pkg
// Widths, constants, codes and types of the predicate filter bitmap block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfb_pkg;

   // field widths
   localparam int ELEM_W     = 32;
   localparam int WORD_BITS  = 64;
   localparam int POS_W      = 6;
   localparam int WORD_IDX_W = 18;
   localparam int MATCH_W    = 25;
   localparam int MODE_W     = 3;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // limits
   localparam longint unsigned MAX_ELEMENTS    = 64'd16777216;
   localparam longint unsigned MATCH_FIELD_MAX = 64'd33554431;
   localparam longint unsigned MATCH_CAP_L     =
      (MAX_ELEMENTS < MATCH_FIELD_MAX) ? MAX_ELEMENTS : MATCH_FIELD_MAX;

   typedef logic        [ELEM_W-1:0]     element_type;
   typedef logic        [WORD_BITS-1:0]  bitmap_type;
   typedef logic        [POS_W-1:0]      bit_pos_type;
   typedef logic        [WORD_IDX_W-1:0] word_idx_type;
   typedef logic        [MATCH_W-1:0]    match_cnt_type;
   typedef logic        [MODE_W-1:0]     mode_type;
   typedef logic        [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic        [CSR_DATA_W-1:0] csr_data_type;

   localparam match_cnt_type MATCH_CAP      = MATCH_W'(MATCH_CAP_L);
   localparam word_idx_type  WORD_IDX_MAX   = {WORD_IDX_W{1'b1}};
   localparam bit_pos_type   LAST_POS       = {POS_W{1'b1}};

   // compare modes
   localparam mode_type MODE_GT    = 3'd0;
   localparam mode_type MODE_GE    = 3'd1;
   localparam mode_type MODE_LT    = 3'd2;
   localparam mode_type MODE_LE    = 3'd3;
   localparam mode_type MODE_EQ    = 3'd4;
   localparam mode_type MODE_NE    = 3'd5;
   localparam mode_type MODE_RANGE = 3'd6;

   // register indexes
   localparam csr_idx_type CSR_COMPARE_MODE = 2'd0;
   localparam csr_idx_type CSR_THRESHOLD    = 2'd1;
   localparam csr_idx_type CSR_UPPER_BOUND  = 2'd2;

endpackage

// ----- rtl/pfb_req_if.sv -----
// ----------------------------------------------------------------------------
// pfb_req_if
// Input channel: one column value per beat, with its last-of-array flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfb_req_if;
   logic                 valid;
   logic                 ready;
   pfb_pkg::element_type element;
   logic                 last_element;

   modport source (output valid, output element, output last_element, input ready);
   modport sink   (input valid, input element, input last_element, output ready);
endinterface

// ----- rtl/pfb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pfb_rsp_if
// Result channel: one selection word per beat with its index and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfb_rsp_if;
   logic                   valid;
   logic                   ready;
   pfb_pkg::bitmap_type    bitmap_word;
   pfb_pkg::word_idx_type  word_index;
   pfb_pkg::match_cnt_type match_total;
   logic                   final_word;

   modport source (output valid, output bitmap_word, output word_index,
                   output match_total, output final_word, input ready);
   modport sink   (input valid, input bitmap_word, input word_index,
                   input match_total, input final_word, output ready);
endinterface

// ----- rtl/predicate_filter_bitmap.sv -----
// ----------------------------------------------------------------------------
// predicate_filter_bitmap
// Predicate scan over a column stream, packing match bits into 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one signed 32-bit value per beat plus last_element.
//   rsp_bus carries a selection word once 64 values are gathered or when the
//   last value of an array arrives, with its word index, the running match
//   count of the array and final_word.
//   csr_* writes compare_mode (0), threshold_value (1) and upper_bound (2);
//   write only while no beat is in flight.
// Timing:
//   A beat is held in the input register, then the compare and bit insert run
//   into the result register, which presents the word until rsp_bus.ready
//   takes it. One beat is accepted every cycle unless a beat that closes a
//   word meets a full result register that rsp_bus is holding off.
// Reset:
//   Synchronous, active high. Clears configuration, valid flags, accumulator and
//   counters; req_bus.ready stays low while reset is held.
// Stall:
//   While rsp_bus is held off, the result register holds its word; beats that
//   produce no word still advance, and the input stalls only when a beat that
//   closes a word meets a full result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "predicate_filter_bitmap_defines.svh"

module predicate_filter_bitmap (
   input  logic                 clock,
   input  logic                 reset,
   pfb_req_if.sink              req_bus,
   pfb_rsp_if.source            rsp_bus,
   input  logic                 csr_write_en,
   input  pfb_pkg::csr_idx_type csr_index,
   input  pfb_pkg::csr_data_type csr_wdata
);
   import pfb_pkg::*;

   // configuration registers
   mode_type           mode_ff;
   logic signed [31:0] threshold_ff;
   logic signed [31:0] upper_ff;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   element_type        s1_elem_ff;
   logic               s1_last_ff;

   // scan state
   bitmap_type         acc_ff, acc_in;
   bit_pos_type        pos_ff, pos_in;
   word_idx_type       word_ff, word_in;
   match_cnt_type      mcnt_ff, mcnt_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   bitmap_type         out_bitmap_ff;
   word_idx_type       out_index_ff;
   match_cnt_type      out_total_ff;
   logic               out_final_ff;

   logic               match;
   logic               emit;
   logic               out_free;
   logic               proc;
   bitmap_type         acc_set;
   match_cnt_type      mcnt_next;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_GT;
         threshold_ff <= '0;
         upper_ff     <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_COMPARE_MODE: mode_ff      <= csr_wdata[MODE_W-1:0];
            CSR_THRESHOLD:    threshold_ff <= $signed(csr_wdata);
            CSR_UPPER_BOUND:  upper_ff     <= $signed(csr_wdata);
            default:          ;
         endcase
      end
   end

   // predicate
   always_comb begin
      logic signed [31:0] x;
      x = $signed(s1_elem_ff);
      unique case (mode_ff)
         MODE_GT:    match = x >  threshold_ff;
         MODE_GE:    match = x >= threshold_ff;
         MODE_LT:    match = x <  threshold_ff;
         MODE_LE:    match = x <= threshold_ff;
         MODE_EQ:    match = x == threshold_ff;
         MODE_NE:    match = x != threshold_ff;
         MODE_RANGE: match = (x >= threshold_ff) && (x < upper_ff);
         default:    match = 1'b0;
      endcase
   end

   // handshake: stage 2 runs unless a word would land on a held result
   assign emit     = (pos_ff == LAST_POS) || s1_last_ff;
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign proc     = s1_valid_ff && (!emit || out_free);
   assign req_bus.ready = !reset && (!s1_valid_ff || proc);

   assign s1_valid_in = req_bus.ready ? req_bus.valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_elem_ff <= req_bus.element;
         s1_last_ff <= req_bus.last_element;
      end
   end

   // bit insert and saturating counters
   assign acc_set   = acc_ff | (WORD_BITS'(match) << pos_ff);
   assign mcnt_next = (match && (mcnt_ff < MATCH_CAP)) ? mcnt_ff + 1'b1 : mcnt_ff;

   always_comb begin
      acc_in  = acc_ff;
      pos_in  = pos_ff;
      word_in = word_ff;
      mcnt_in = mcnt_ff;
      if (proc) begin
         if (emit && s1_last_ff) begin
            acc_in  = '0;
            pos_in  = '0;
            word_in = '0;
            mcnt_in = '0;
         end else if (emit) begin
            acc_in  = '0;
            pos_in  = '0;
            word_in = (word_ff < WORD_IDX_MAX) ? word_ff + 1'b1 : word_ff;
            mcnt_in = mcnt_next;
         end else begin
            acc_in  = acc_set;
            pos_in  = pos_ff + 1'b1;
            mcnt_in = mcnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= '0;
         word_ff <= '0;
         mcnt_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         word_ff <= word_in;
         mcnt_ff <= mcnt_in;
      end
   end

   // result register
   assign out_valid_in = (proc && emit) ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) begin
         out_bitmap_ff <= acc_set;
         out_index_ff  <= word_ff;
         out_total_ff  <= mcnt_next;
         out_final_ff  <= s1_last_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.bitmap_word = out_bitmap_ff;
   assign rsp_bus.word_index  = out_index_ff;
   assign rsp_bus.match_total = out_total_ff;
   assign rsp_bus.final_word  = out_final_ff;

   // checks
   `PFB_ASSERT_NEXT(a_clear_after_last, clock, reset, proc && emit && s1_last_ff, pos_ff == '0 && word_ff == '0 && mcnt_ff == '0 && acc_ff == '0)
   `PFB_ASSERT_NOW(a_count_capped, clock, reset, 1'b1, mcnt_ff <= MATCH_CAP)
   `PFB_ASSERT_NOW(a_no_overrun, clock, reset, s1_valid_ff && !proc, !req_bus.ready && out_valid_ff && !rsp_bus.ready)

endmodule

// ----- tb/sv/tb_predicate_filter_bitmap.sv -----
// ----------------------------------------------------------------------------
// tb_predicate_filter_bitmap
// Self-checking regression for the predicate scan bitmap packer.
// ----------------------------------------------------------------------------
// Column values stream in on req_if. An in-bench model of the predicate,
// the bit packing and the word and match counters turns each accepted beat
// into the selection word it should close, if any. Words from rsp_if are
// checked in order, field by field. Directed arrays cover every compare
// mode at the extremes of the threshold, the range and empty-range cases,
// the unused mode and writes to the unused register slot. Random phases then
// reprogram the registers and stream arrays of mixed length, some cut off
// before their last beat, with random gaps on the sender and back-pressure
// on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_predicate_filter_bitmap;
   import pfb_pkg::*;

   localparam mode_type    MODE_UNUSED    = 3'd7;
   localparam csr_idx_type CSR_UNUSED     = 2'd3;
   localparam element_type INT_MIN        = 32'h8000_0000;
   localparam element_type INT_MAX        = 32'h7FFF_FFFF;
   localparam element_type MINUS_ONE      = 32'hFFFF_FFFF;
   localparam int          SETTLE_CYCLES  = 6;
   localparam int          RANDOM_BEATS   = 1520;
   localparam int          REPORT_LIMIT   = 10;
   localparam longint      TIMEOUT_NS     = 64'd12_000_000;

   typedef struct packed {
      bitmap_type    bitmap;
      word_idx_type  index;
      match_cnt_type total;
      logic          fin;
   } sel_word_type;

   logic         clock;
   logic         reset;
   logic         csr_write_en;
   csr_idx_type  csr_index;
   csr_data_type csr_wdata;

   pfb_req_if req_if ();
   pfb_rsp_if rsp_if ();

   predicate_filter_bitmap u_top (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_if),
      .rsp_bus      (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // model copy of the registers
   mode_type           cfg_mode      = MODE_GT;
   logic signed [31:0] cfg_threshold = '0;
   logic signed [31:0] cfg_upper     = '0;

   // model copy of the packing state
   bitmap_type    sel_bits    = '0;
   bit_pos_type   sel_pos     = '0;
   word_idx_type  sel_word_idx = '0;
   match_cnt_type sel_matches = '0;

   sel_word_type pending_words[$];
   int        mismatch_count = 0;
   int        beats_sent     = 0;
   int        words_seen     = 0;
   bit        send_gaps      = 1'b0;
   bit        rsp_stalls     = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("predicate_filter_bitmap regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic logic value_selected(element_type v);
      logic signed [31:0] x;
      x = v;
      unique case (cfg_mode)
         MODE_GT:    return x > cfg_threshold;
         MODE_GE:    return x >= cfg_threshold;
         MODE_LT:    return x < cfg_threshold;
         MODE_LE:    return x <= cfg_threshold;
         MODE_EQ:    return x == cfg_threshold;
         MODE_NE:    return x != cfg_threshold;
         MODE_RANGE: return (x >= cfg_threshold) && (x < cfg_upper);
         default:    return 1'b0;
      endcase
   endfunction

   function automatic void pack_beat(element_type v, logic last);
      if (value_selected(v)) begin
         sel_bits[sel_pos] = 1'b1;
         if (sel_matches < MATCH_CAP)
            sel_matches++;
      end
      if (sel_pos == LAST_POS || last) begin
         pending_words.push_back('{sel_bits, sel_word_idx, sel_matches, last});
         sel_bits = '0;
         sel_pos  = '0;
         if (last) begin
            sel_word_idx = '0;
            sel_matches  = '0;
         end else if (sel_word_idx < WORD_IDX_MAX) begin
            sel_word_idx++;
         end
      end else begin
         sel_pos++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_value(input element_type v, input logic last);
      int gap;
      gap = send_gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.element      <= v;
      req_if.last_element <= last;
      do @(posedge clock); while (!req_if.ready);
      pack_beat(v, last);
      beats_sent++;
   endtask

   // hold the sender until every word is back and the pipe has emptied
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input csr_data_type data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      unique case (idx)
         CSR_COMPARE_MODE: cfg_mode      = data[MODE_W-1:0];
         CSR_THRESHOLD:    cfg_threshold = data;
         CSR_UPPER_BOUND:  cfg_upper     = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_triplet(input element_type center);
      send_value(center - element_type'(1), 1'b0);
      send_value(center, 1'b0);
      send_value(center + element_type'(1), 1'b1);
   endtask

   function automatic element_type pick_bound();
      unique case ($urandom_range(0, 9))
         0:       return INT_MIN;
         1:       return INT_MAX;
         2:       return '0;
         3, 4, 5: return element_type'($urandom_range(0, 200)) - element_type'(100);
         default: return element_type'($urandom());
      endcase
   endfunction

   // values cluster around the bounds so that both outcomes are common
   function automatic element_type pick_element();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35)
         return element_type'(cfg_threshold) + element_type'($urandom_range(0, 6))
                - element_type'(3);
      if (r < 50)
         return element_type'(cfg_upper) + element_type'($urandom_range(0, 6))
                - element_type'(3);
      if (r < 60) begin
         unique case ($urandom_range(0, 3))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return '0;
            default: return MINUS_ONE;
         endcase
      end
      return element_type'($urandom());
   endfunction

   function automatic int pick_array_len();
      unique case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(1, 70);
         5, 6: begin
            unique case ($urandom_range(0, 3))
               0:       return 63;
               1:       return 64;
               2:       return 65;
               default: return 128;
            endcase
         end
         7, 8:    return $urandom_range(71, 200);
         default: return $urandom_range(200, 400);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // result side: ready generator and word checker
   // ------------------------------------------------------------------------
   initial begin : rsp_ready_gen
      int n;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         n = rsp_stalls ? gap_length() : 0;
         if (n > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         n = $urandom_range(1, 16);
         repeat (n) @(posedge clock);
      end
   end

   task automatic log_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin : word_check
      sel_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            log_error($sformatf("unexpected word: bitmap %h index %0d total %0d final %b",
                                rsp_if.bitmap_word, rsp_if.word_index,
                                rsp_if.match_total, rsp_if.final_word));
         end else begin
            want = pending_words.pop_front();
            if (rsp_if.bitmap_word !== want.bitmap || rsp_if.word_index !== want.index ||
                rsp_if.match_total !== want.total || rsp_if.final_word !== want.fin)
               log_error($sformatf({"word %0d mismatch: expected bitmap %h index %0d ",
                                    "total %0d final %b, got bitmap %h index %0d ",
                                    "total %0d final %b"},
                                   words_seen, want.bitmap, want.index, want.total,
                                   want.fin, rsp_if.bitmap_word, rsp_if.word_index,
                                   rsp_if.match_total, rsp_if.final_word));
         end
         words_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // registers at their reset values: greater than zero
   task automatic test_reset_values();
      send_value(INT_MIN, 1'b0);
      send_value(element_type'(1), 1'b1);
      wait_idle();
   endtask

   // each compare against a value just below, at and just above the threshold
   task automatic test_compare_modes();
      mode_type    modes[7];
      element_type bounds[7];
      modes  = '{MODE_GT, MODE_GE, MODE_LT, MODE_LE, MODE_EQ, MODE_NE, MODE_UNUSED};
      bounds = '{INT_MAX, INT_MIN, 32'd0, MINUS_ONE, 32'h0001_2345, 32'h8000_0001, 32'd0};
      foreach (modes[i]) begin
         write_reg(CSR_COMPARE_MODE, csr_data_type'(modes[i]));
         write_reg(CSR_THRESHOLD, bounds[i]);
         send_triplet(bounds[i]);
         wait_idle();
      end
   endtask

   // half-open range, then bounds that leave it empty
   task automatic test_range_mode();
      write_reg(CSR_COMPARE_MODE, csr_data_type'(MODE_RANGE));
      write_reg(CSR_THRESHOLD, element_type'(-5));
      write_reg(CSR_UPPER_BOUND, element_type'(5));
      send_value(element_type'(-6), 1'b0);
      send_value(element_type'(-5), 1'b0);
      send_value(element_type'(4), 1'b0);
      send_value(element_type'(5), 1'b1);
      wait_idle();
      write_reg(CSR_THRESHOLD, element_type'(5));
      send_value(element_type'(5), 1'b1);
      wait_idle();
      write_reg(CSR_THRESHOLD, INT_MAX);
      write_reg(CSR_UPPER_BOUND, INT_MIN);
      send_value(INT_MAX, 1'b1);
      wait_idle();
   endtask

   // a write to the unused slot must leave every register alone
   task automatic test_unused_index();
      write_reg(CSR_COMPARE_MODE, csr_data_type'(MODE_EQ));
      write_reg(CSR_THRESHOLD, element_type'(7));
      write_reg(CSR_UNUSED, csr_data_type'(MODE_NE));
      send_value(element_type'(7), 1'b1);
      wait_idle();
   endtask

   task automatic program_random();
      mode_type     mode;
      csr_data_type upper_bits;
      mode       = mode_type'($urandom_range(0, 7));
      upper_bits = $urandom() & 32'hFFFF_FFF8;
      write_reg(CSR_COMPARE_MODE, upper_bits | csr_data_type'(mode));
      write_reg(CSR_THRESHOLD, pick_bound());
      if (mode == MODE_RANGE && $urandom_range(0, 9) < 6)
         write_reg(CSR_UPPER_BOUND,
                   element_type'(cfg_threshold) + element_type'($urandom_range(1, 2000)));
      else
         write_reg(CSR_UPPER_BOUND, pick_bound());
      if ($urandom_range(0, 4) == 0)
         write_reg(CSR_UNUSED, $urandom());
   endtask

   // phases of random arrays, each with its own register setting and idling
   task automatic test_random_traffic();
      int target;
      int budget;
      int len;
      bit cut;
      target = beats_sent + RANDOM_BEATS;
      while (beats_sent < target) begin
         wait_idle();
         program_random();
         send_gaps  = ($urandom_range(0, 3) != 0);
         rsp_stalls = ($urandom_range(0, 3) != 0);
         budget     = $urandom_range(60, 160);
         while (budget > 0 && beats_sent < target) begin
            len = pick_array_len();
            cut = 1'b0;
            // sometimes stop mid-array so the partial word spans a reprogram
            if (len > budget && $urandom_range(0, 1)) begin
               len = budget;
               cut = 1'b1;
            end
            // keep the total beat count on target
            if (len > target - beats_sent)
               len = target - beats_sent;
            for (int i = 0; i < len; i++)
               send_value(pick_element(), (i == len - 1) && !cut);
            budget -= len;
            if ($urandom_range(0, 9) == 0)
               wait_idle();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_COMPARE_MODE;
      csr_wdata           <= '0;
      req_if.valid        <= 1'b0;
      req_if.element      <= '0;
      req_if.last_element <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gaps  = 1'b1;
      rsp_stalls = 1'b1;
      test_reset_values();
      test_compare_modes();
      test_range_mode();
      test_unused_index();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0)
         $display("predicate_filter_bitmap regression: pass");
      else
         $display("predicate_filter_bitmap regression: fail");
      $finish;
   end

endmodule

// ----- predicate_filter_bitmap.f -----
+incdir+rtl
rtl/pfb_pkg.sv
rtl/pfb_req_if.sv
rtl/pfb_rsp_if.sv
rtl/predicate_filter_bitmap.sv
tb/sv/tb_predicate_filter_bitmap.sv
